FILE: design/qdc_pkg.sv
package qdc_pkg;

  // Width of the position counter
  localparam int COUNT_BITS = 7;
  // Width of the limit registers and of the reported count
  localparam int LIMIT_W = 7;
  localparam int COUNT_OUT_W = 7;
  // Compare width wide enough for both the counter and the limits
  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  // Configuration register indexes
  localparam logic REG_MENU_LIMIT     = 1'b0;
  localparam logic REG_SETPOINT_LIMIT = 1'b1;

  // Reset values
  localparam logic [1:0]         PREV_AB_RST        = 2'b11;
  localparam logic [LIMIT_W-1:0] MENU_LIMIT_RST     = 7'd4;
  localparam logic [LIMIT_W-1:0] SETPOINT_LIMIT_RST = 7'd70;

  typedef logic signed [2:0] acc_t;

  // Detent thresholds: report above +2 or below -2
  localparam acc_t ACC_HI = 3'sd2;
  localparam acc_t ACC_LO = -3'sd2;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    MODE_HOME = 2'd0,
    MODE_MENU = 2'd1,
    MODE_SET  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]            prev_ab;
    acc_t                  acc;
    logic [COUNT_BITS-1:0] pos;
  } dec_state_t;

  typedef struct packed {
    dir_t                   dir;
    logic [COUNT_OUT_W-1:0] count;
  } dec_result_t;

  // Quadrature transition table indexed by {prev_a, prev_b, a, b}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default:                  s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

FILE: design/qdc_step.sv
module qdc_step import qdc_pkg::*; (
  input  dec_state_t         cur_state,
  input  logic               pin_a,
  input  logic               pin_b,
  input  logic [1:0]         ui_mode,
  input  logic [LIMIT_W-1:0] menu_limit,
  input  logic [LIMIT_W-1:0] setpoint_limit,
  output dec_state_t         next_state,
  output dec_result_t        result
);

  logic [1:0]        cur_ab;
  logic signed [1:0] step;
  acc_t              acc_sum;
  acc_t              acc_nxt;
  logic [LIMIT_W-1:0] limit;
  logic              moving;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  limit_ext;
  logic              can_inc;
  logic              can_dec;
  logic [COUNT_BITS-1:0] pos_nxt;
  logic [CMP_W-1:0]  pos_nxt_ext;
  dir_t              dir;

  // Table lookup and accumulate
  assign cur_ab  = {pin_a, pin_b};
  assign step    = quad_step({cur_state.prev_ab, cur_ab});
  assign acc_sum = cur_state.acc + acc_t'(step);

  // Active limit per mode; unused mode code acts like home
  always_comb begin
    case (ui_mode)
      MODE_MENU: begin
        limit  = menu_limit;
        moving = 1'b1;
      end
      MODE_SET: begin
        limit  = setpoint_limit;
        moving = 1'b1;
      end
      default: begin
        limit  = '0;
        moving = 1'b0;
      end
    endcase
  end

  assign pos_ext   = CMP_W'(cur_state.pos);
  assign limit_ext = CMP_W'(limit);
  assign can_inc   = moving && (pos_ext < limit_ext) && !(&cur_state.pos);
  assign can_dec   = moving && (cur_state.pos != '0);

  // Detent decision and counter move
  always_comb begin
    dir     = DIR_NONE;
    pos_nxt = cur_state.pos;
    acc_nxt = acc_sum;
    if (acc_sum > ACC_HI) begin
      dir = DIR_CW;
      acc_nxt = '0;
      if (can_inc) begin
        pos_nxt = cur_state.pos + COUNT_BITS'(1);
      end
    end else if (acc_sum < ACC_LO) begin
      dir = DIR_CCW;
      acc_nxt = '0;
      if (can_dec) begin
        pos_nxt = cur_state.pos - COUNT_BITS'(1);
      end
    end
  end

  assign next_state.prev_ab = cur_ab;
  assign next_state.acc     = acc_nxt;
  assign next_state.pos     = pos_nxt;

  assign pos_nxt_ext  = CMP_W'(pos_nxt);
  assign result.dir   = dir;
  assign result.count = pos_nxt_ext[COUNT_OUT_W-1:0];

endmodule

FILE: design/quadrature_detent_counter.sv
// Rotary encoder decoder with a detent counter. Each request carries one sample of the
// two encoder pins and the current UI mode (home, menu, set temperature) and yields
// exactly one result: the detent direction seen on this sample and the counter value
// after it. Requests are taken one per clock; the result is captured in the output
// register on acceptance, and in_ready stays high while that register is empty or being
// drained, so the sustained rate is one sample per cycle while out_ready is high. Limits
// are written through cfg_we/cfg_index/cfg_data and should only be changed while idle.
// After reset the pins are assumed high, the menu limit is 4 and the setpoint limit 70.
module quadrature_detent_counter import qdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_pin_a,
  input  logic                   in_pin_b,
  input  logic [1:0]             in_ui_mode,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_direction,
  output logic [COUNT_OUT_W-1:0] out_count_value,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [LIMIT_W-1:0]     cfg_data
);

  logic [LIMIT_W-1:0] menu_limit_r;
  logic [LIMIT_W-1:0] setpoint_limit_r;
  dec_state_t         state_r;
  dec_state_t         state_nxt;
  dec_result_t        result_r;
  dec_result_t        result_nxt;
  logic               out_valid_r;
  logic               in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Per-sample decode
  qdc_step u_step (
    .cur_state      (state_r),
    .pin_a          (in_pin_a),
    .pin_b          (in_pin_b),
    .ui_mode        (in_ui_mode),
    .menu_limit     (menu_limit_r),
    .setpoint_limit (setpoint_limit_r),
    .next_state     (state_nxt),
    .result         (result_nxt)
  );

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_limit_r     <= MENU_LIMIT_RST;
      setpoint_limit_r <= SETPOINT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MENU_LIMIT:     menu_limit_r     <= cfg_data;
        REG_SETPOINT_LIMIT: setpoint_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prev_ab <= PREV_AB_RST;
      state_r.acc     <= '0;
      state_r.pos     <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_direction   = result_r.dir;
  assign out_count_value = result_r.count;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import qdc_pkg::*;

  // Unused UI mode code, decoded like home
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX = 10;
  localparam int N_PHASES = 8;

  // Step of {prev_a, prev_b, a, b}: +1 clockwise, -1 counter-clockwise
  localparam int TURN_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  // Pin pairs {a, b} in clockwise order
  localparam logic [1:0] CW_ORDER [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  typedef struct packed {
    logic                   a;
    logic                   b;
    logic [1:0]             mode;
    logic                   fixed;
    dir_t                   dir;
    logic [COUNT_OUT_W-1:0] count;
  } probe_row_t;

  // Directed requests; fixed rows carry the hand-derived result
  localparam probe_row_t PROBES [24] = '{
    '{1'b1, 1'b1, MODE_HOME,  1'b1, DIR_NONE, 7'd0},  // no motion after reset
    '{1'b0, 1'b1, MODE_MENU,  1'b1, DIR_NONE, 7'd0},
    '{1'b0, 1'b0, MODE_MENU,  1'b1, DIR_NONE, 7'd0},
    '{1'b1, 1'b0, MODE_MENU,  1'b1, DIR_CW,   7'd1},  // first clockwise detent
    '{1'b1, 1'b1, MODE_MENU,  1'b0, DIR_NONE, 7'd0},
    '{1'b0, 1'b0, MODE_MENU,  1'b0, DIR_NONE, 7'd0},  // both pins jump
    '{1'b1, 1'b1, MODE_MENU,  1'b0, DIR_NONE, 7'd0},  // and back
    '{1'b1, 1'b0, MODE_SET,   1'b0, DIR_NONE, 7'd0},
    '{1'b0, 1'b0, MODE_SET,   1'b0, DIR_NONE, 7'd0},
    '{1'b0, 1'b1, MODE_SET,   1'b0, DIR_NONE, 7'd0},
    '{1'b1, 1'b1, MODE_SET,   1'b0, DIR_NONE, 7'd0},
    '{1'b1, 1'b0, MODE_SET,   1'b0, DIR_NONE, 7'd0},
    '{1'b0, 1'b0, MODE_SET,   1'b0, DIR_NONE, 7'd0},
    '{1'b0, 1'b1, MODE_SET,   1'b1, DIR_CCW,  7'd0},  // ccw detent holds at zero
    '{1'b0, 1'b0, MODE_SPARE, 1'b0, DIR_NONE, 7'd0},
    '{1'b1, 1'b0, MODE_SPARE, 1'b0, DIR_NONE, 7'd0},
    '{1'b1, 1'b1, MODE_SPARE, 1'b1, DIR_CW,   7'd0},  // spare mode: report only
    '{1'b1, 1'b1, MODE_MENU,  1'b0, DIR_NONE, 7'd0},  // no pin change
    '{1'b0, 1'b1, MODE_MENU,  1'b0, DIR_NONE, 7'd0},
    '{1'b0, 1'b0, MODE_MENU,  1'b0, DIR_NONE, 7'd0},
    '{1'b1, 1'b0, MODE_MENU,  1'b0, DIR_NONE, 7'd0},
    '{1'b0, 1'b0, MODE_HOME,  1'b0, DIR_NONE, 7'd0},
    '{1'b0, 1'b1, MODE_HOME,  1'b0, DIR_NONE, 7'd0},
    '{1'b1, 1'b1, MODE_HOME,  1'b0, DIR_NONE, 7'd0}   // home: count stays
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_pin_a;
  logic                   in_pin_b;
  logic [1:0]             in_ui_mode;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             out_direction;
  logic [COUNT_OUT_W-1:0] out_count_value;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [LIMIT_W-1:0]     cfg_data;

  // Fixed result of the request on the bus, if any
  logic                   row_fixed;
  dir_t                   row_dir;
  logic [COUNT_OUT_W-1:0] row_count;

  // Decoder state mirror
  logic [1:0]             enc_prev_ab;
  logic signed [2:0]      enc_acc;
  logic [COUNT_BITS-1:0]  enc_pos;
  logic [LIMIT_W-1:0]     lim_menu;
  logic [LIMIT_W-1:0]     lim_setpoint;

  dec_result_t            pending_detents[$];
  int                     mismatches = 0;
  int                     idle_cycles = 0;
  bit                     no_gaps = 1'b0;

  quadrature_detent_counter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pin_a        (in_pin_a),
    .in_pin_b        (in_pin_b),
    .in_ui_mode      (in_ui_mode),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_direction   (out_direction),
    .out_count_value (out_count_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the decoder mirror by one pin sample and return its result
  function automatic dec_result_t decode_detent(logic a, logic b, logic [1:0] mode);
    logic [1:0]         cur_ab;
    int                 acc_sum;
    logic [LIMIT_W-1:0] lim;
    logic               moves;
    dec_result_t        res;
    cur_ab = {a, b};
    acc_sum = int'(enc_acc) + TURN_STEP[{enc_prev_ab, cur_ab}];
    enc_prev_ab = cur_ab;
    moves = 1'b1;
    lim = '0;
    case (mode)
      MODE_MENU: lim = lim_menu;
      MODE_SET:  lim = lim_setpoint;
      default:   moves = 1'b0;
    endcase
    res.dir = DIR_NONE;
    if (acc_sum > 2) begin
      res.dir = DIR_CW;
      if (moves && enc_pos < lim && enc_pos != '1)
        enc_pos = enc_pos + 1'b1;
      acc_sum = 0;
    end else if (acc_sum < -2) begin
      res.dir = DIR_CCW;
      if (moves && enc_pos != '0)
        enc_pos = enc_pos - 1'b1;
      acc_sum = 0;
    end
    enc_acc = acc_sum[2:0];
    res.count = enc_pos;
    return res;
  endfunction

  task automatic flag_mismatch(string what, dec_result_t want);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] %s: expected dir %0d count %0d, got dir %0d count %0d", $time, what,
               want.dir, want.count, out_direction, out_count_value);
  endtask

  // Result check and request capture, both at the rising edge
  always @(posedge clk) begin : result_check
    dec_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_detents.size() == 0) begin
          flag_mismatch("result with no request pending", '0);
        end else begin
          want = pending_detents.pop_front();
          if (out_direction !== want.dir || out_count_value !== want.count)
            flag_mismatch("result mismatch", want);
        end
      end
      if (in_valid && in_ready) begin
        want = decode_detent(in_pin_a, in_pin_b, in_ui_mode);
        if (row_fixed) begin
          want.dir = row_dir;
          want.count = row_count;
        end
        pending_detents.push_back(want);
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= no_gaps || ($urandom_range(0, 99) >= 18);
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("** quadrature_detent_counter: FAILED **");
      $finish;
    end
  end

  // Present one request and hold it until taken; returns at a falling edge
  task automatic send_sample(logic a, logic b, logic [1:0] mode, logic fixed, dir_t dir,
                             logic [COUNT_OUT_W-1:0] count);
    while (!no_gaps && $urandom_range(0, 99) < 18) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_pin_a = a;
    in_pin_b = b;
    in_ui_mode = mode;
    row_fixed = fixed;
    row_dir = dir;
    row_count = count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_detents.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(logic idx, logic [LIMIT_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_MENU_LIMIT)
      lim_menu = val;
    else
      lim_setpoint = val;
  endtask

  initial begin : stimulus
    int                 n_items;
    int                 cw_pct;
    int                 burst_left;
    int                 pick;
    bit                 burst_cw;
    bit                 moving_only;
    logic [1:0]         walk_idx;
    logic [1:0]         burst_mode;
    logic [1:0]         ab;
    logic [LIMIT_W-1:0] m_lim;
    logic [LIMIT_W-1:0] s_lim;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pin_a = 1'b1;
    in_pin_b = 1'b1;
    in_ui_mode = MODE_HOME;
    row_fixed = 1'b0;
    row_dir = DIR_NONE;
    row_count = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MENU_LIMIT;
    cfg_data = '0;
    enc_prev_ab = 2'b11;
    enc_acc = '0;
    enc_pos = '0;
    lim_menu = 7'd4;
    lim_setpoint = 7'd70;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset limits
    foreach (PROBES[i])
      send_sample(PROBES[i].a, PROBES[i].b, PROBES[i].mode, PROBES[i].fixed,
                  PROBES[i].dir, PROBES[i].count);
    wait_drained();

    // Random phases: gray-code walks in bursts, with some pin noise
    walk_idx = 2'd0;
    burst_left = 0;
    burst_cw = 1'b1;
    burst_mode = MODE_MENU;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin m_lim = 7'd0;   s_lim = 7'd127; end
        1: begin m_lim = 7'd127; s_lim = 7'd0;   end
        2: begin m_lim = 7'd127; s_lim = 7'd127; end
        3: begin m_lim = 7'd2;   s_lim = 7'd3;   end
        default: begin
          m_lim = LIMIT_W'($urandom_range(0, 127));
          s_lim = LIMIT_W'($urandom_range(0, 127));
        end
      endcase
      write_limit(REG_MENU_LIMIT, m_lim);
      write_limit(REG_SETPOINT_LIMIT, s_lim);
      // Phase 2 drives the count up to saturation, phase 3 starts above the limits
      n_items = (ph == 2) ? 500 : 110;
      cw_pct = (ph == 2) ? 97 : (ph == 3) ? 35 : 50;
      moving_only = (ph == 2);
      no_gaps = (ph == 4);
      repeat (n_items) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          burst_cw = $urandom_range(0, 99) < cw_pct;
          pick = $urandom_range(0, 99);
          if (moving_only)
            burst_mode = (pick < 50) ? MODE_MENU : MODE_SET;
          else
            burst_mode = (pick < 35) ? MODE_MENU : (pick < 70) ? MODE_SET :
                         (pick < 88) ? MODE_HOME : MODE_SPARE;
        end
        burst_left--;
        if ($urandom_range(0, 99) < 8)
          walk_idx = 2'($urandom_range(0, 3));
        else
          walk_idx = burst_cw ? walk_idx + 2'd1 : walk_idx - 2'd1;
        ab = CW_ORDER[walk_idx];
        send_sample(ab[1], ab[0], burst_mode, 1'b0, DIR_NONE, '0);
      end
      wait_drained();
    end
    no_gaps = 1'b0;

    if (mismatches == 0 && pending_detents.size() == 0)
      $display("** quadrature_detent_counter: PASSED **");
    else
      $display("** quadrature_detent_counter: FAILED **");
    $finish;
  end

endmodule
